// ===== design/aabb_circle_contact_assert.svh =====
// assertion macros shared by the contact block
`ifndef AABB_CIRCLE_CONTACT_ASSERT_SVH
`define AABB_CIRCLE_CONTACT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ACC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aabb_circle_contact: check failed");

// next-cycle implication, checked outside reset
`define ACC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aabb_circle_contact: check failed");

`endif

// ===== design/acc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package acc_pkg;

    localparam int COORD_W          = 24;
    localparam int SIZE_W           = 23;
    localparam int POS_W            = 27;   // doubled coordinate plus headroom
    localparam int MAG_W            = 26;
    localparam int NORM_W           = 16;
    localparam int PEN_W            = 26;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int SHIFT_LIM_W      = 24;
    localparam int LEN_SHIFT        = 14;
    localparam int NUM_SHIFT        = NORMAL_FRAC_BITS + 7;
    localparam int SQ_IN_W          = 64;
    localparam int LEN_W            = SQ_IN_W / 2;
    localparam int NUM_W            = SHIFT_LIM_W + NUM_SHIFT + 1;
    localparam int QUO_W            = 16;
    localparam int FIFO_DEPTH       = 4;
    localparam int IN_TDATA_W       = 168;
    localparam int OUT_TDATA_W      = 64;

    localparam int Q_ONE_INT        = 1 << NORMAL_FRAC_BITS;
    localparam int Q_LIM_INT        = (Q_ONE_INT < 32767) ? Q_ONE_INT : 32767;

    typedef struct packed {
        logic             in_box;
        logic             neg_x;
        logic             neg_y;
        logic [MAG_W-1:0] mag_x;
        logic [MAG_W-1:0] mag_y;
        logic [SIZE_W-1:0] radius;
    } t_item;

endpackage
`default_nettype wire

// ===== design/acc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module acc_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [acc_pkg::COORD_W-1:0]  i_box_center_x,
    input  logic signed [acc_pkg::COORD_W-1:0]  i_box_center_y,
    input  logic        [acc_pkg::SIZE_W-1:0]   i_box_width,
    input  logic        [acc_pkg::SIZE_W-1:0]   i_box_height,
    input  logic signed [acc_pkg::COORD_W-1:0]  i_circle_center_x,
    input  logic signed [acc_pkg::COORD_W-1:0]  i_circle_center_y,
    input  logic        [acc_pkg::SIZE_W-1:0]   i_circle_radius,
    input  logic                                i_full,
    output logic                                o_push,
    output acc_pkg::t_item                      o_item
);
    localparam int PW = acc_pkg::POS_W;
    localparam int CW = acc_pkg::COORD_W;
    localparam int SW = acc_pkg::SIZE_W;
    localparam int MW = acc_pkg::MAG_W;

    logic signed [PW-1:0] w_bx, w_by, w_px, w_py, w_ex, w_ey, w_ofx, w_ofy;
    logic signed [PW-1:0] w_ofx_abs, w_ofy_abs;

    logic                 r_valid;
    logic signed [PW-1:0] r_lox, r_hix, r_loy, r_hiy, r_px, r_py;
    logic [MW-1:0]        r_ofx_mag, r_ofy_mag;
    logic                 r_ofx_neg, r_ofy_neg;
    logic [SW-1:0]        r_rad;

    // doubled coordinates keep the half sizes exact
    assign w_bx = {{(PW-CW-1){i_box_center_x[CW-1]}}, i_box_center_x, 1'b0};
    assign w_by = {{(PW-CW-1){i_box_center_y[CW-1]}}, i_box_center_y, 1'b0};
    assign w_px = {{(PW-CW-1){i_circle_center_x[CW-1]}}, i_circle_center_x, 1'b0};
    assign w_py = {{(PW-CW-1){i_circle_center_y[CW-1]}}, i_circle_center_y, 1'b0};
    assign w_ex = {{(PW-SW){1'b0}}, i_box_width};
    assign w_ey = {{(PW-SW){1'b0}}, i_box_height};
    assign w_ofx = w_px - w_bx;
    assign w_ofy = w_py - w_by;
    assign w_ofx_abs = w_ofx[PW-1] ? -w_ofx : w_ofx;
    assign w_ofy_abs = w_ofy[PW-1] ? -w_ofy : w_ofy;

    assign o_ready = !r_valid || !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_lox     <= w_bx - w_ex;
            r_hix     <= w_bx + w_ex;
            r_loy     <= w_by - w_ey;
            r_hiy     <= w_by + w_ey;
            r_px      <= w_px;
            r_py      <= w_py;
            r_ofx_mag <= w_ofx_abs[MW-1:0];
            r_ofy_mag <= w_ofy_abs[MW-1:0];
            r_ofx_neg <= w_ofx[PW-1];
            r_ofy_neg <= w_ofy[PW-1];
            r_rad     <= i_circle_radius;
        end
    end

    logic                 w_inside, w_use_x;
    logic signed [PW-1:0] w_nx, w_ny, w_nx_abs, w_ny_abs;

    always_comb begin
        w_inside = (r_px >= r_lox) && (r_px <= r_hix) && (r_py >= r_loy) && (r_py <= r_hiy);
        w_use_x  = r_ofx_mag > r_ofy_mag;
        if (w_inside) begin
            // move to the face on the centre's own side
            if (w_use_x) begin
                w_nx = (r_ofx_neg ? r_lox : r_hix) - r_px;
                w_ny = '0;
            end else begin
                w_nx = '0;
                w_ny = (r_ofy_neg ? r_loy : r_hiy) - r_py;
            end
        end else begin
            w_nx = (r_px < r_lox) ? (r_px - r_lox) : ((r_px > r_hix) ? (r_px - r_hix) : '0);
            w_ny = (r_py < r_loy) ? (r_py - r_loy) : ((r_py > r_hiy) ? (r_py - r_hiy) : '0);
        end
        w_nx_abs = w_nx[PW-1] ? -w_nx : w_nx;
        w_ny_abs = w_ny[PW-1] ? -w_ny : w_ny;
    end

    assign o_push        = r_valid && !i_full;
    assign o_item.in_box = w_inside;
    assign o_item.neg_x  = w_nx[PW-1];
    assign o_item.neg_y  = w_ny[PW-1];
    assign o_item.mag_x  = w_nx_abs[MW-1:0];
    assign o_item.mag_y  = w_ny_abs[MW-1:0];
    assign o_item.radius = r_rad;

endmodule
`default_nettype wire

// ===== design/acc_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module acc_fifo #(
    parameter int DEPTH = acc_pkg::FIFO_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  acc_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output acc_pkg::t_item o_item,
    output logic           o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    acc_pkg::t_item r_mem [DEPTH];
    logic [AW-1:0]  r_wr, r_rd;
    logic [AW:0]    r_count;

    assign o_full  = r_count == (AW+1)'(DEPTH);
    assign o_empty = r_count == '0;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule
`default_nettype wire

// ===== design/acc_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// pipelined integer square root, one result bit per stage
module acc_sqrt #(
    parameter int IN_W = acc_pkg::SQ_IN_W,
    parameter int TW   = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_ce,
    input  logic                i_valid,
    input  logic [IN_W-1:0]     i_x,
    input  logic [TW-1:0]       i_tag,
    output logic                o_valid,
    output logic [IN_W/2-1:0]   o_root,
    output logic [TW-1:0]       o_tag
);
    localparam int OW = IN_W / 2;
    localparam int RW = OW + 3;

    logic [RW-1:0]   r_rem  [OW+1];
    logic [OW-1:0]   r_root [OW+1];
    logic [IN_W-1:0] r_x    [OW+1];
    logic [TW-1:0]   r_tag  [OW+1];
    logic            r_v    [OW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_ce) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_x[0]    <= i_x;
            r_tag[0]  <= i_tag;
        end
    end

    for (genvar k = 0; k < OW; k++) begin : g_stage
        logic [RW-1:0] w_t, w_trial;
        assign w_t     = {r_rem[k][RW-3:0], r_x[k][IN_W-1 -: 2]};
        assign w_trial = RW'({r_root[k], 2'b01});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_ce) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                if (w_t >= w_trial) begin
                    r_rem[k+1]  <= w_t - w_trial;
                    r_root[k+1] <= {r_root[k][OW-2:0], 1'b1};
                end else begin
                    r_rem[k+1]  <= w_t;
                    r_root[k+1] <= {r_root[k][OW-2:0], 1'b0};
                end
                r_x[k+1]   <= {r_x[k][IN_W-3:0], 2'b00};
                r_tag[k+1] <= r_tag[k];
            end
        end
    end

    assign o_valid = r_v[OW];
    assign o_root  = r_root[OW];
    assign o_tag   = r_tag[OW];

endmodule
`default_nettype wire

// ===== design/acc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// pipelined restoring divider, one quotient bit per stage;
// the numerator must stay below the divisor shifted up by QW
module acc_div #(
    parameter int NW = acc_pkg::NUM_W,
    parameter int DW = acc_pkg::LEN_W,
    parameter int QW = acc_pkg::QUO_W,
    parameter int TW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_ce,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [TW-1:0] i_tag,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic [TW-1:0] o_tag
);
    logic [DW-1:0] r_rem [QW+1];
    logic [QW-1:0] r_low [QW+1];
    logic [DW-1:0] r_den [QW+1];
    logic [QW-1:0] r_quo [QW+1];
    logic [TW-1:0] r_tag [QW+1];
    logic          r_v   [QW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_ce) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_rem[0] <= DW'(i_num[NW-1:QW]);
            r_low[0] <= i_num[QW-1:0];
            r_den[0] <= i_den;
            r_quo[0] <= '0;
            r_tag[0] <= i_tag;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW:0] w_t, w_d;
        assign w_t = {r_rem[k], r_low[k][QW-1]};
        assign w_d = {1'b0, r_den[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_ce) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                if (w_t >= w_d) begin
                    r_rem[k+1] <= DW'(w_t - w_d);
                    r_quo[k+1] <= {r_quo[k][QW-2:0], 1'b1};
                end else begin
                    r_rem[k+1] <= DW'(w_t);
                    r_quo[k+1] <= {r_quo[k][QW-2:0], 1'b0};
                end
                r_low[k+1] <= {r_low[k][QW-2:0], 1'b0};
                r_den[k+1] <= r_den[k];
                r_tag[k+1] <= r_tag[k];
            end
        end
    end

    assign o_valid = r_v[QW];
    assign o_quo   = r_quo[QW];
    assign o_tag   = r_tag[QW];

endmodule
`default_nettype wire

// ===== design/acc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module acc_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_empty,
    input  acc_pkg::t_item                      i_item,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_hit,
    output logic signed [acc_pkg::NORM_W-1:0]   o_normal_x,
    output logic signed [acc_pkg::NORM_W-1:0]   o_normal_y,
    output logic signed [acc_pkg::PEN_W-1:0]    o_pen
);
    localparam int MW   = acc_pkg::MAG_W;
    localparam int SW   = acc_pkg::SIZE_W;
    localparam int LW   = acc_pkg::SHIFT_LIM_W;
    localparam int XW   = acc_pkg::SQ_IN_W;
    localparam int RTW  = acc_pkg::LEN_W;
    localparam int NW   = acc_pkg::NUM_W;
    localparam int QW   = acc_pkg::QUO_W;
    localparam int OW   = acc_pkg::NORM_W;
    localparam int PW   = acc_pkg::PEN_W;
    localparam int SQW  = 2 * MW;
    localparam int D2W  = SQW + 1;
    localparam int R2W  = 2 * SW;
    localparam int PSW  = MW + 2;
    localparam int PIW  = PSW - 1;
    localparam int SSW  = MW;
    localparam int TW_L = 5 + 2 * LW;
    localparam int TW_S = PIW + SW;
    localparam int TW_X = 5 + PIW;
    localparam int TW_Y = SSW + SW;
    localparam int FW   = 28;

    localparam logic [QW-1:0]        QLIM  = QW'(acc_pkg::Q_LIM_INT);
    localparam logic signed [FW-1:0] P_MAX = FW'((1 << (PW - 1)) - 1);
    localparam logic signed [FW-1:0] P_MIN = -FW'(1 << (PW - 1));

    logic w_ce;
    logic r_o_valid;

    // whole back end moves together; output register lets the queue keep filling
    assign w_ce  = !r_o_valid || i_ready;
    assign o_pop = w_ce && !i_empty;

    // stage 0: queue head
    logic           r_v0;
    acc_pkg::t_item r_i0;

    // stage 1: squares
    logic           r_v1;
    acc_pkg::t_item r_i1;
    logic [SQW-1:0] r_a2, r_b2;
    logic [R2W-1:0] r_r2;

    // stage 2: hit test, inside depth, magnitude scaling
    logic           r_v2, r_hit2, r_in2, r_zero2, r_negx2, r_negy2;
    logic [LW-1:0]  r_as2, r_bs2;
    logic [PIW-1:0] r_pin2;
    logic [XW-1:0]  r_x4_2;
    logic [SW-1:0]  r_rad2;

    // stage 3: squares of scaled magnitudes
    logic           r_v3, r_hit3, r_in3, r_zero3, r_negx3, r_negy3;
    logic [LW-1:0]  r_as3, r_bs3;
    logic [2*LW-1:0] r_asq3, r_bsq3;
    logic [PIW-1:0] r_pin3;
    logic [XW-1:0]  r_x4_3;
    logic [SW-1:0]  r_rad3;

    // stage 4: sqrt operands
    logic           r_v4;
    logic [TW_L-1:0] r_tl4;
    logic [TW_S-1:0] r_ts4;
    logic [XW-1:0]  r_s2x4, r_x4_4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_ce) begin
            r_v0 <= !i_empty;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    logic [D2W-1:0] w_d2;
    logic [PSW-1:0] w_psum;
    logic [MW-1:0]  w_ta, w_tb;

    always_comb begin
        w_d2   = D2W'(r_a2) + D2W'(r_b2);
        w_psum = PSW'({r_i1.radius, 1'b0}) + PSW'(r_i1.mag_x) + PSW'(r_i1.mag_y) + PSW'(1);
        w_ta   = r_i1.mag_x;
        w_tb   = r_i1.mag_y;
        for (int k = 0; k < MW - LW; k++) begin
            if ((|w_ta[MW-1:LW]) || (|w_tb[MW-1:LW])) begin
                w_ta = w_ta >> 1;
                w_tb = w_tb >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_i0 <= i_item;

            r_i1 <= r_i0;
            r_a2 <= SQW'(r_i0.mag_x) * SQW'(r_i0.mag_x);
            r_b2 <= SQW'(r_i0.mag_y) * SQW'(r_i0.mag_y);
            r_r2 <= R2W'(r_i0.radius) * R2W'(r_i0.radius);

            r_hit2  <= r_i1.in_box || (w_d2 < D2W'({r_r2, 2'b00}));
            r_in2   <= r_i1.in_box;
            r_zero2 <= (r_i1.mag_x == '0) && (r_i1.mag_y == '0);
            r_negx2 <= r_i1.neg_x;
            r_negy2 <= r_i1.neg_y;
            r_as2   <= w_ta[LW-1:0];
            r_bs2   <= w_tb[LW-1:0];
            r_pin2  <= w_psum[PSW-1:1];
            r_x4_2  <= XW'({w_d2, 2'b00});
            r_rad2  <= r_i1.radius;

            r_hit3  <= r_hit2;
            r_in3   <= r_in2;
            r_zero3 <= r_zero2;
            r_negx3 <= r_negx2;
            r_negy3 <= r_negy2;
            r_as3   <= r_as2;
            r_bs3   <= r_bs2;
            r_asq3  <= (2*LW)'(r_as2) * (2*LW)'(r_as2);
            r_bsq3  <= (2*LW)'(r_bs2) * (2*LW)'(r_bs2);
            r_pin3  <= r_pin2;
            r_x4_3  <= r_x4_2;
            r_rad3  <= r_rad2;

            r_tl4  <= {r_hit3, r_in3, r_zero3, r_negx3, r_negy3, r_as3, r_bs3};
            r_ts4  <= {r_pin3, r_rad3};
            r_s2x4 <= XW'({(2*LW+1)'(r_asq3) + (2*LW+1)'(r_bsq3),
                           acc_pkg::LEN_SHIFT'(0)});
            r_x4_4 <= r_x4_3;
        end
    end

    logic            w_vl, w_vs;
    logic [RTW-1:0]  w_len, w_s;
    logic [TW_L-1:0] w_tl;
    logic [TW_S-1:0] w_ts;

    acc_sqrt #(.IN_W(XW), .TW(TW_L)) u_sqrt_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (r_v4),
        .i_x     (r_s2x4),
        .i_tag   (r_tl4),
        .o_valid (w_vl),
        .o_root  (w_len),
        .o_tag   (w_tl)
    );

    acc_sqrt #(.IN_W(XW), .TW(TW_S)) u_sqrt_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (r_v4),
        .i_x     (r_x4_4),
        .i_tag   (r_ts4),
        .o_valid (w_vs),
        .o_root  (w_s),
        .o_tag   (w_ts)
    );

    logic          w_hitl, w_inl, w_zerol, w_negxl, w_negyl;
    logic [LW-1:0] w_asl, w_bsl;
    logic [PIW-1:0] w_pinl;
    logic [SW-1:0] w_radl;
    logic [NW-1:0] w_numx, w_numy;

    assign {w_hitl, w_inl, w_zerol, w_negxl, w_negyl, w_asl, w_bsl} = w_tl;
    assign {w_pinl, w_radl} = w_ts;
    assign w_numx = (NW'(w_asl) << acc_pkg::NUM_SHIFT) + NW'(w_len >> 1);
    assign w_numy = (NW'(w_bsl) << acc_pkg::NUM_SHIFT) + NW'(w_len >> 1);

    logic            w_vx, w_vy;
    logic [QW-1:0]   w_qx, w_qy;
    logic [TW_X-1:0] w_tx;
    logic [TW_Y-1:0] w_ty;

    acc_div #(.NW(NW), .DW(RTW), .QW(QW), .TW(TW_X)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (w_vl && w_vs),
        .i_num   (w_numx),
        .i_den   (w_len),
        .i_tag   ({w_hitl, w_inl, w_zerol, w_negxl, w_negyl, w_pinl}),
        .o_valid (w_vx),
        .o_quo   (w_qx),
        .o_tag   (w_tx)
    );

    acc_div #(.NW(NW), .DW(RTW), .QW(QW), .TW(TW_Y)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (w_vl && w_vs),
        .i_num   (w_numy),
        .i_den   (w_len),
        .i_tag   ({w_s[SSW-1:0], w_radl}),
        .o_valid (w_vy),
        .o_quo   (w_qy),
        .o_tag   (w_ty)
    );

    logic           w_hitf, w_inf, w_zerof, w_negxf, w_negyf;
    logic [PIW-1:0] w_pinf;
    logic [SSW-1:0] w_sf;
    logic [SW-1:0]  w_radf;
    logic [QW-1:0]  w_qxc, w_qyc;
    logic signed [OW-1:0] w_nx, w_ny;
    logic signed [FW-1:0] w_t, w_pen_raw, w_pen_sat;

    assign {w_hitf, w_inf, w_zerof, w_negxf, w_negyf, w_pinf} = w_tx;
    assign {w_sf, w_radf} = w_ty;

    always_comb begin
        w_qxc = (w_qx > QLIM) ? QLIM : w_qx;
        w_qyc = (w_qy > QLIM) ? QLIM : w_qy;
        if (w_hitf && !w_zerof) begin
            w_nx = w_negxf ? -OW'(w_qxc) : OW'(w_qxc);
            w_ny = w_negyf ? -OW'(w_qyc) : OW'(w_qyc);
        end else begin
            w_nx = '0;
            w_ny = '0;
        end
        // outside: (4r - s + 2) / 4, never negative on a hit
        w_t = $signed(FW'({w_radf, 2'b10})) - $signed(FW'(w_sf));
        if (!w_hitf) begin
            w_pen_raw = '0;
        end else if (w_inf) begin
            w_pen_raw = $signed(FW'(w_pinf));
        end else begin
            w_pen_raw = w_t >>> 2;
        end
        if (w_pen_raw > P_MAX) begin
            w_pen_sat = P_MAX;
        end else if (w_pen_raw < P_MIN) begin
            w_pen_sat = P_MIN;
        end else begin
            w_pen_sat = w_pen_raw;
        end
    end

    logic                 r_hit;
    logic signed [OW-1:0] r_nx, r_ny;
    logic signed [PW-1:0] r_pen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_ce) begin
            r_o_valid <= w_vx && w_vy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_hit <= w_hitf;
            r_nx  <= w_nx;
            r_ny  <= w_ny;
            r_pen <= w_pen_sat[PW-1:0];
        end
    end

    assign o_valid    = r_o_valid;
    assign o_hit      = r_hit;
    assign o_normal_x = r_nx;
    assign o_normal_y = r_ny;
    assign o_pen      = r_pen;

endmodule
`default_nettype wire

// ===== design/aabb_circle_contact.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel      direction  tdata fields (lowest bit first)
// s_axis       in         box_center_x, box_center_y, box_width, box_height,
//                         circle_center_x, circle_center_y, circle_radius
// m_axis       out        contact_hit, normal_x, normal_y, penetration_depth
//
// one item per cycle sustained while m_axis_tready stays high; the path runs through
// the two 33-stage square roots and the two 17-stage dividers
// the front classifies into a 4-entry queue, so input keeps flowing while
// the back end waits on m_axis_tready
// synchronous active-low reset clears all valid and queue state
module aabb_circle_contact (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // box_center_x, box_center_y, box_width, box_height,
    // circle_center_x, circle_center_y, circle_radius, zero pad
    input  logic [acc_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // contact_hit, normal_x, normal_y, penetration_depth, zero pad
    output logic [acc_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata
);
    localparam int CW = acc_pkg::COORD_W;
    localparam int SW = acc_pkg::SIZE_W;
    localparam int OW = acc_pkg::NORM_W;
    localparam int PW = acc_pkg::PEN_W;
    localparam int IU = 4 * CW + 3 * SW;
    localparam int OU = 1 + 2 * OW + PW;

    logic           w_push, w_full, w_pop, w_empty;
    acc_pkg::t_item w_fitem, w_qitem;
    logic           w_hit;
    logic signed [OW-1:0] w_nx, w_ny;
    logic signed [PW-1:0] w_pen;

    acc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_s_axis_tvalid),
        .o_ready           (o_s_axis_tready),
        .i_box_center_x    (i_s_axis_tdata[CW-1:0]),
        .i_box_center_y    (i_s_axis_tdata[2*CW-1:CW]),
        .i_box_width       (i_s_axis_tdata[2*CW+SW-1:2*CW]),
        .i_box_height      (i_s_axis_tdata[2*CW+2*SW-1:2*CW+SW]),
        .i_circle_center_x (i_s_axis_tdata[3*CW+2*SW-1:2*CW+2*SW]),
        .i_circle_center_y (i_s_axis_tdata[4*CW+2*SW-1:3*CW+2*SW]),
        .i_circle_radius   (i_s_axis_tdata[IU-1:4*CW+2*SW]),
        .i_full            (w_full),
        .o_push            (w_push),
        .o_item            (w_fitem)
    );

    acc_fifo #(.DEPTH(acc_pkg::FIFO_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_fitem),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_item  (w_qitem),
        .o_empty (w_empty)
    );

    acc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (w_empty),
        .i_item     (w_qitem),
        .o_pop      (w_pop),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_hit      (w_hit),
        .o_normal_x (w_nx),
        .o_normal_y (w_ny),
        .o_pen      (w_pen)
    );

    assign o_m_axis_tdata = {{(acc_pkg::OUT_TDATA_W-OU){1'b0}}, w_pen, w_ny, w_nx, w_hit};

`include "aabb_circle_contact_assert.svh"

    `ACC_ASSERT_IMP(a_miss_zero, i_clk, i_rst_n, o_m_axis_tvalid && !w_hit, (w_nx == '0) && (w_ny == '0) && (w_pen == '0))
    `ACC_ASSERT_IMP(a_depth_sign, i_clk, i_rst_n, o_m_axis_tvalid && w_hit, !w_pen[PW-1])
    `ACC_ASSERT_IMP(a_normal_range, i_clk, i_rst_n, o_m_axis_tvalid, (w_nx <= $signed(OW'(acc_pkg::Q_LIM_INT))) && (w_nx >= -$signed(OW'(acc_pkg::Q_LIM_INT))) && (w_ny <= $signed(OW'(acc_pkg::Q_LIM_INT))) && (w_ny >= -$signed(OW'(acc_pkg::Q_LIM_INT))))
    `ACC_ASSERT_NEXT(a_queue_pop, i_clk, i_rst_n, w_empty && !w_push, !w_pop)

endmodule
`default_nettype wire
